FILE: hw/rtl/etm_pkg.sv
// Types, field widths and codes shared by the exposure timer.
// No dependencies; compile before the interfaces and modules.
`timescale 1ns / 1ps

package etm_pkg;

   localparam int CMD_W    = 3;
   localparam int TIME_W   = 32;
   localparam int TENTHS_W = 15;
   localparam int LAG_W    = 16;
   localparam int RUN_W    = 2;
   localparam int BEEP_W   = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PAUSE       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESUME      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STOP        = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESET       = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RESET_TOTAL = 3'd6;

   // Run state codes
   localparam logic [RUN_W-1:0] RUN_STOPPED = 2'd0;
   localparam logic [RUN_W-1:0] RUN_ACTIVE  = 2'd1;
   localparam logic [RUN_W-1:0] RUN_PAUSED  = 2'd2;

   // Beeper codes
   localparam logic [BEEP_W-1:0] BEEP_NONE     = 2'd0;
   localparam logic [BEEP_W-1:0] BEEP_SHORT    = 2'd1;
   localparam logic [BEEP_W-1:0] BEEP_TONE_ON  = 2'd2;
   localparam logic [BEEP_W-1:0] BEEP_TONE_OFF = 2'd3;

   localparam int MS_PER_TENTH = 100;
   localparam logic [TENTHS_W-1:0] SAT_TENTHS = 15'd32767;
   // Smallest millisecond count whose tenths saturate
   localparam logic [TIME_W-1:0] SAT_MS = 32'd3276800;

   // Division by 100 below SAT_MS: (x * RECIP) >> RECIP_SHIFT
   localparam int DIV_IN_W    = 22;
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 29;
   localparam logic [RECIP_W-1:0] RECIP = 23'd5368710;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [TIME_W-1:0]   now_ms;
      logic [TENTHS_W-1:0] duration_tenths;
   } etm_req_type;

   // Timer state just after one request, plus the per-request flags
   typedef struct packed {
      logic [RUN_W-1:0]  run_state;
      logic [TIME_W-1:0] cur;
      logic [TIME_W-1:0] resume;
      logic [TIME_W-1:0] resume_lag;
      logic [TIME_W-1:0] remaining;
      logic [TIME_W-1:0] stop;
      logic [LAG_W-1:0]  lag;
      logic [TIME_W-1:0] acc;
      logic [TIME_W-1:0] seg_ms;
      logic              stopped;
      logic [BEEP_W-1:0] beep;
      logic              pause_ok;
   } etm_snap_type;

   typedef struct packed {
      logic                relay_on;
      logic [RUN_W-1:0]    run_state;
      logic                just_stopped;
      logic [BEEP_W-1:0]   beep_cmd;
      logic                pause_ok;
      logic                in_lag;
      logic [TIME_W-1:0]   left_ms;
      logic [TENTHS_W-1:0] total_tenths;
      logic [TENTHS_W-1:0] last_segment_tenths;
   } etm_result_type;

   // Exposure counted in the running segment at time cur
   function automatic logic [TIME_W-1:0] exposure_ms(
      input logic              active,
      input logic [TIME_W-1:0] cur,
      input logic [TIME_W-1:0] stop,
      input logic [TIME_W-1:0] resume,
      input logic [TIME_W-1:0] resume_lag,
      input logic [TIME_W-1:0] remaining,
      input logic [LAG_W-1:0]  lag
   );
      logic [TIME_W-1:0] since;
      logic [TIME_W-1:0] res;
      since = cur - resume;
      if (!active) begin
         res = '0;
      end else if (cur > stop) begin
         res = remaining;
      end else if (since < TIME_W'(lag)) begin
         res = '0;
      end else begin
         res = cur - resume_lag;
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/etm_req_if.sv
// Request channel of the exposure timer: valid/ready plus command payload.
// Depends on etm_pkg.
`timescale 1ns / 1ps

interface etm_req_if import etm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [TIME_W-1:0]   now_ms;
   logic [TENTHS_W-1:0] duration_tenths;

   modport source (output valid, cmd, now_ms, duration_tenths, input ready);
   modport sink   (input valid, cmd, now_ms, duration_tenths, output ready);
endinterface

FILE: hw/rtl/etm_rsp_if.sv
// Response channel of the exposure timer: valid/ready plus status payload.
// Depends on etm_pkg.
`timescale 1ns / 1ps

interface etm_rsp_if import etm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                relay_on;
   logic [RUN_W-1:0]    run_state;
   logic                just_stopped;
   logic [BEEP_W-1:0]   beep_cmd;
   logic                pause_ok;
   logic                in_lag;
   logic [TIME_W-1:0]   left_ms;
   logic [TENTHS_W-1:0] total_tenths;
   logic [TENTHS_W-1:0] last_segment_tenths;

   modport source (output valid, relay_on, run_state, just_stopped, beep_cmd, pause_ok,
                   in_lag, left_ms, total_tenths, last_segment_tenths, input ready);
   modport sink   (input valid, relay_on, run_state, just_stopped, beep_cmd, pause_ok,
                   in_lag, left_ms, total_tenths, last_segment_tenths, output ready);
endinterface

FILE: hw/rtl/exposure_timer_with_lag_unit.sv
// Top level of the exposure timer with relay lag: handshake pipeline around
// the state core and the status stages. Depends on etm_pkg, etm_req_if,
// etm_rsp_if, etm_core and etm_report.
`timescale 1ns / 1ps

// Usage
//   req_chan (sink): one request per valid/ready handshake, carrying a
//     command (tick, start, pause, resume, stop, reset, reset total), the
//     millisecond time for ticks and the duration in tenths for starts.
//   rsp_chan (source): exactly one status response per request, in order:
//     relay drive, run state, just-stopped, beeper command, pause result,
//     lag flag, remaining ms and total / last segment in tenths.
//   csr_wr_en / csr_wr_data: write the relay lag in ms; write only while
//     no request is in flight.
// Timing
//   Four register stages: request register, state update, exposure and
//   remaining-time stage, tenths conversion (two 22x23 multiplies) into the
//   response register. An accepted request passes through them in that
//   order before its response is offered. One request per cycle is
//   sustained while the receiver takes every response; the state update, a
//   single add/compare step, closes the request-to-request loop.
// Reset and stalls
//   Synchronous reset clears the timer to stopped with zero times and a
//   zero lag, and empties the pipeline. A stalled receiver holds the
//   response; bubbles further up still fill, so requests keep being taken
//   until all four stages are occupied.

module exposure_timer_with_lag_unit import etm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   etm_req_if.sink          req_chan,
   etm_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [LAG_W-1:0] csr_wr_data
);

   logic           a_v_ff, a_v_in;
   logic           b_v_ff, b_v_in;
   logic           c_v_ff, c_v_in;
   logic           d_v_ff, d_v_in;
   logic           a_ready, b_ready, c_ready, d_ready;
   etm_req_type    a_ff;
   etm_snap_type   snap;
   etm_result_type result;

   // Ready ripples back from the receiver; an empty stage always takes data
   assign d_ready = !d_v_ff || rsp_chan.ready;
   assign c_ready = !c_v_ff || d_ready;
   assign b_ready = !b_v_ff || c_ready;
   assign a_ready = !a_v_ff || b_ready;

   assign req_chan.ready = a_ready;

   // Advance each valid when its stage may load, else hold
   assign a_v_in = a_ready ? req_chan.valid : a_v_ff;
   assign b_v_in = b_ready ? a_v_ff : b_v_ff;
   assign c_v_in = c_ready ? b_v_ff : c_v_ff;
   assign d_v_in = d_ready ? c_v_ff : d_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
         d_v_ff <= d_v_in;
      end
   end

   // Capture the request payload on acceptance
   always_ff @(posedge clock) begin
      if (req_chan.valid && a_ready) begin
         a_ff.cmd             <= req_chan.cmd;
         a_ff.now_ms          <= req_chan.now_ms;
         a_ff.duration_tenths <= req_chan.duration_tenths;
      end
   end

   // State update fires when the held request moves into the snapshot stage
   etm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (a_v_ff && b_ready),
      .req         (a_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .snap        (snap)
   );

   etm_report u_report (
      .clock  (clock),
      .c_load (b_v_ff && c_ready),
      .d_load (c_v_ff && d_ready),
      .snap   (snap),
      .result (result)
   );

   // Drive the response channel straight from the response register
   assign rsp_chan.valid               = d_v_ff;
   assign rsp_chan.relay_on            = result.relay_on;
   assign rsp_chan.run_state           = result.run_state;
   assign rsp_chan.just_stopped        = result.just_stopped;
   assign rsp_chan.beep_cmd            = result.beep_cmd;
   assign rsp_chan.pause_ok            = result.pause_ok;
   assign rsp_chan.in_lag              = result.in_lag;
   assign rsp_chan.left_ms             = result.left_ms;
   assign rsp_chan.total_tenths        = result.total_tenths;
   assign rsp_chan.last_segment_tenths = result.last_segment_tenths;

`ifndef SYNTHESIS
   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      !d_v_ff |-> req_chan.ready)
      else $error("request side blocked while the response register is empty");
   a_no_lost_stage: assert property (@(posedge clock) disable iff (reset)
      c_v_ff && !d_ready |=> c_v_ff && d_v_ff)
      else $error("stalled status stage dropped its request");
   a_relay_matches_state: assert property (@(posedge clock) disable iff (reset)
      d_v_ff |-> rsp_chan.relay_on == (rsp_chan.run_state == RUN_ACTIVE))
      else $error("relay drive disagrees with run state");
`endif

endmodule

FILE: hw/rtl/etm_core.sv
// Timer state registers and command decode; one request per step.
// Depends on etm_pkg.
`timescale 1ns / 1ps

module etm_core import etm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  etm_req_type        req,
   input  logic               csr_wr_en,
   input  logic [LAG_W-1:0]   csr_wr_data,
   output etm_snap_type       snap
);

   logic [RUN_W-1:0]  run_ff, run_in;
   logic [TIME_W-1:0] cur_ff, cur_in;
   logic [TIME_W-1:0] resume_ff, resume_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] acc_ff, acc_in;
   logic [TIME_W-1:0] seg_ff, seg_in;
   logic              lagp_ff, lagp_in;
   logic              stopped_ff, stopped_in;
   logic [LAG_W-1:0]  lag_ff, lag_in;
   // Derived sums kept in step with the state above
   logic [TIME_W-1:0] stop_ff, stop_in;      // resume + remaining + lag
   logic [TIME_W-1:0] rlag_ff, rlag_in;      // resume + lag
   logic [TIME_W-1:0] clag_ff, clag_in;      // current time + lag
   etm_snap_type      snap_ff;

   logic [BEEP_W-1:0] beep;
   logic              pok;
   logic              active;
   logic [TIME_W-1:0] cur_eff;
   logic [TIME_W-1:0] ex;
   logic              reached;
   logic [TIME_W-1:0] rem_start;
   logic [TIME_W-1:0] stop_start;
   logic [TIME_W-1:0] stop_add;

   assign active    = (run_ff == RUN_ACTIVE);
   assign cur_eff   = (req.cmd == CMD_TICK) ? req.now_ms : cur_ff;
   assign ex        = exposure_ms(active, cur_eff, stop_ff, resume_ff, rlag_ff, rem_ff, lag_ff);
   assign reached   = (cur_eff >= stop_ff);
   assign rem_start = TIME_W'(req.duration_tenths) * TIME_W'(MS_PER_TENTH);
   assign stop_start = clag_ff + rem_start;
   assign stop_add  = reached ? rem_ff : ex;

   always_comb begin
      run_in     = run_ff;
      cur_in     = cur_ff;
      resume_in  = resume_ff;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      seg_in     = seg_ff;
      lagp_in    = lagp_ff;
      stopped_in = stopped_ff;
      lag_in     = lag_ff;
      stop_in    = stop_ff;
      rlag_in    = rlag_ff;
      clag_in    = clag_ff;
      beep       = BEEP_NONE;
      pok        = 1'b0;
      if (step) begin
         unique case (req.cmd)
            CMD_TICK: begin
               cur_in     = req.now_ms;
               clag_in    = req.now_ms + TIME_W'(lag_ff);
               stopped_in = 1'b0;
               if (active) begin
                  if (ex != '0) begin
                     seg_in = ex;
                  end
                  if (reached) begin
                     stopped_in = 1'b1;
                     beep       = BEEP_TONE_OFF;
                     acc_in     = acc_ff + rem_ff;
                     run_in     = RUN_STOPPED;
                     rem_in     = '0;
                     stop_in    = rlag_ff;
                  end else if (!lagp_ff && ex >= TIME_W'(MS_PER_TENTH)) begin
                     lagp_in = 1'b1;
                     beep    = BEEP_TONE_ON;
                  end
               end
            end
            CMD_START: begin
               beep = BEEP_SHORT;
               if (req.duration_tenths == '0) begin
                  stopped_in = 1'b1;
               end else begin
                  lagp_in   = 1'b0;
                  rem_in    = rem_start;
                  resume_in = cur_ff;
                  run_in    = RUN_ACTIVE;
                  rlag_in   = clag_ff;
                  stop_in   = stop_start;
                  // stop time wrapped below now: the whole run counts at once
                  if (cur_ff > stop_start) begin
                     seg_in = rem_start;
                  end
               end
            end
            CMD_PAUSE: begin
               if (active) begin
                  beep = BEEP_TONE_OFF;
                  if (ex != '0) begin
                     seg_in = ex;
                  end
                  acc_in  = acc_ff + ex;
                  rem_in  = rem_ff - ex;
                  stop_in = stop_ff - ex;
                  run_in  = RUN_PAUSED;
                  pok     = (cur_ff > rlag_ff);
               end
            end
            CMD_RESUME: begin
               if (run_ff == RUN_PAUSED) begin
                  beep      = BEEP_SHORT;
                  lagp_in   = 1'b0;
                  resume_in = cur_ff;
                  run_in    = RUN_ACTIVE;
                  rlag_in   = clag_ff;
                  stop_in   = clag_ff + rem_ff;
               end
            end
            CMD_STOP, CMD_RESET: begin
               if (run_ff != RUN_STOPPED) begin
                  beep = BEEP_TONE_OFF;
                  if (ex != '0) begin
                     seg_in = ex;
                  end
                  acc_in  = acc_ff + stop_add;
                  run_in  = RUN_STOPPED;
                  rem_in  = '0;
                  stop_in = rlag_ff;
               end
               if (req.cmd == CMD_RESET) begin
                  acc_in = '0;
                  seg_in = '0;
               end
            end
            CMD_RESET_TOTAL: begin
               acc_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (csr_wr_en) begin
         lag_in  = csr_wr_data;
         stop_in = resume_ff + rem_ff + TIME_W'(csr_wr_data);
         rlag_in = resume_ff + TIME_W'(csr_wr_data);
         clag_in = cur_ff + TIME_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= RUN_STOPPED;
         cur_ff     <= '0;
         resume_ff  <= '0;
         rem_ff     <= '0;
         acc_ff     <= '0;
         seg_ff     <= '0;
         lagp_ff    <= 1'b0;
         stopped_ff <= 1'b0;
         lag_ff     <= '0;
         stop_ff    <= '0;
         rlag_ff    <= '0;
         clag_ff    <= '0;
      end else begin
         run_ff     <= run_in;
         cur_ff     <= cur_in;
         resume_ff  <= resume_in;
         rem_ff     <= rem_in;
         acc_ff     <= acc_in;
         seg_ff     <= seg_in;
         lagp_ff    <= lagp_in;
         stopped_ff <= stopped_in;
         lag_ff     <= lag_in;
         stop_ff    <= stop_in;
         rlag_ff    <= rlag_in;
         clag_ff    <= clag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         snap_ff.run_state  <= run_in;
         snap_ff.cur        <= cur_in;
         snap_ff.resume     <= resume_in;
         snap_ff.resume_lag <= rlag_in;
         snap_ff.remaining  <= rem_in;
         snap_ff.stop       <= stop_in;
         snap_ff.lag        <= lag_in;
         snap_ff.acc        <= acc_in;
         snap_ff.seg_ms     <= seg_in;
         snap_ff.stopped    <= stopped_in;
         snap_ff.beep       <= beep;
         snap_ff.pause_ok   <= pok;
      end
   end

   assign snap = snap_ff;

`ifndef SYNTHESIS
   a_stop_sum: assert property (@(posedge clock) disable iff (reset)
      stop_ff == resume_ff + rem_ff + TIME_W'(lag_ff))
      else $error("stop time out of step with resume, remaining and lag");
   a_rlag_sum: assert property (@(posedge clock) disable iff (reset)
      rlag_ff == resume_ff + TIME_W'(lag_ff))
      else $error("resume plus lag out of step");
   a_clag_sum: assert property (@(posedge clock) disable iff (reset)
      clag_ff == cur_ff + TIME_W'(lag_ff))
      else $error("current time plus lag out of step");
   a_stopped_empty: assert property (@(posedge clock) disable iff (reset)
      run_ff == RUN_STOPPED |-> rem_ff == '0)
      else $error("remaining time left over while stopped");
`endif

endmodule

FILE: hw/rtl/etm_report.sv
// Status stages: exposure, remaining time and tenths conversion of a snapshot.
// Depends on etm_pkg.
`timescale 1ns / 1ps

module etm_report import etm_pkg::*; (
   input  logic           clock,
   input  logic           c_load,
   input  logic           d_load,
   input  etm_snap_type   snap,
   output etm_result_type result
);

   typedef struct packed {
      logic              relay_on;
      logic [RUN_W-1:0]  run_state;
      logic              just_stopped;
      logic [BEEP_W-1:0] beep_cmd;
      logic              pause_ok;
      logic              in_lag;
      logic [TIME_W-1:0] left_ms;
      logic [TIME_W-1:0] sum_ms;
      logic [TIME_W-1:0] seg_ms;
   } expo_type;

   expo_type          c_ff, c_in;
   etm_result_type    d_ff;
   logic              active;
   logic [TIME_W-1:0] ex;

   function automatic logic [TENTHS_W-1:0] ms_to_tenths(input logic [TIME_W-1:0] ms);
      logic [DIV_IN_W+RECIP_W-1:0] prod;
      logic [TENTHS_W-1:0]         res;
      prod = (DIV_IN_W + RECIP_W)'(ms[DIV_IN_W-1:0]) * (DIV_IN_W + RECIP_W)'(RECIP);
      if (ms >= SAT_MS) begin
         res = SAT_TENTHS;
      end else begin
         res = prod[RECIP_SHIFT +: TENTHS_W];
      end
      return res;
   endfunction

   assign active = (snap.run_state == RUN_ACTIVE);
   assign ex = exposure_ms(active, snap.cur, snap.stop, snap.resume, snap.resume_lag,
                           snap.remaining, snap.lag);

   always_comb begin
      c_in.relay_on     = active;
      c_in.run_state    = snap.run_state;
      c_in.just_stopped = snap.stopped;
      c_in.beep_cmd     = snap.beep;
      c_in.pause_ok     = snap.pause_ok;
      c_in.in_lag       = active && (ex == '0);
      c_in.left_ms      = (active && ex != '0) ? (snap.stop - snap.cur) : snap.remaining;
      c_in.sum_ms       = snap.acc + ex;
      c_in.seg_ms       = snap.seg_ms;
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_ff <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (d_load) begin
         d_ff.relay_on            <= c_ff.relay_on;
         d_ff.run_state           <= c_ff.run_state;
         d_ff.just_stopped        <= c_ff.just_stopped;
         d_ff.beep_cmd            <= c_ff.beep_cmd;
         d_ff.pause_ok            <= c_ff.pause_ok;
         d_ff.in_lag              <= c_ff.in_lag;
         d_ff.left_ms             <= c_ff.left_ms;
         d_ff.total_tenths        <= ms_to_tenths(c_ff.sum_ms);
         d_ff.last_segment_tenths <= ms_to_tenths(c_ff.seg_ms);
      end
   end

   assign result = d_ff;

endmodule

FILE: bench/exposure_timer_with_lag_unit_test.sv
// Self-checking bench for exposure_timer_with_lag_unit: a request driver, a response monitor
// and a timer predictor that scores every response in order.
// Depends on etm_pkg, etm_req_if, etm_rsp_if and the unit itself.
`timescale 1ns / 1ps

module exposure_timer_with_lag_unit_test;
   import etm_pkg::*;

   // Spare command code: the unit must treat it as a no-op
   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
   // Idle odds per cycle on each side, in percent
   localparam int unsigned IDLE_PCT = 28;
   // Length of the forced receiver hold-off, in cycles
   localparam int HOLD_CYCLES = 80;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LAG_W-1:0] csr_wr_data;

   etm_req_if req_chan ();
   etm_rsp_if rsp_chan ();

   exposure_timer_with_lag_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Requests still to be offered, and responses the predictor says are due
   etm_req_type    cmd_backlog[$];
   etm_result_type status_due[$];

   etm_req_type held_rq;            // request currently on the bus
   logic        steady;             // drop all random idling while set
   int          stall_asks;         // receiver hold-offs asked for
   int          stall_served;       // receiver hold-offs started
   int          hold_left;          // cycles left in the current hold-off
   int          mismatches;
   int          sent_count;
   int          checked_count;
   int          queued_total;
   int          lag_writes;
   logic [TIME_W-1:0] gen_now;      // wall clock that the stimulus follows

   // Predicted timer state, advanced once per accepted request
   logic [LAG_W-1:0]  lag_reg;
   logic [RUN_W-1:0]  t_state;
   logic [TIME_W-1:0] t_now;
   logic [TIME_W-1:0] t_resume;
   logic [TIME_W-1:0] t_left;
   logic [TIME_W-1:0] t_acc;
   logic [15:0]       t_seg;
   logic              t_lag_done;
   logic              t_stopped;

   // ------------------------------------------------------------------
   // Timer predictor
   // ------------------------------------------------------------------

   // Time at which the running segment ends, lag included; wraps at 2^32
   function automatic logic [TIME_W-1:0] stop_at();
      return t_resume + t_left + TIME_W'(lag_reg);
   endfunction

   // Exposure counted so far in the running segment; the lag never counts
   function automatic logic [TIME_W-1:0] exposed_ms();
      logic [TIME_W-1:0] since;
      if (t_state != RUN_ACTIVE) begin
         return '0;
      end
      if (t_now > stop_at()) begin
         return t_left;
      end
      since = t_now - t_resume;
      if (since < TIME_W'(lag_reg)) begin
         return '0;
      end
      return since - TIME_W'(lag_reg);
   endfunction

   function automatic logic [TENTHS_W-1:0] tenths_sat(input logic [TIME_W-1:0] ms);
      logic [TIME_W-1:0] tenths;
      tenths = ms / TIME_W'(MS_PER_TENTH);
      return (tenths > TIME_W'(SAT_TENTHS)) ? SAT_TENTHS : tenths[TENTHS_W-1:0];
   endfunction

   // Refresh the segment length only once some exposure has been counted
   function automatic void seg_refresh();
      logic [TIME_W-1:0] got;
      got = exposed_ms();
      if (got != '0) begin
         t_seg = 16'(tenths_sat(got));
      end
   endfunction

   // End the run; a paused run past its stop time books the full remainder
   function automatic logic [BEEP_W-1:0] halt_run();
      if (t_state == RUN_STOPPED) begin
         return BEEP_NONE;
      end
      seg_refresh();
      if (t_now >= stop_at()) begin
         t_acc = t_acc + t_left;
      end else begin
         t_acc = t_acc + exposed_ms();
      end
      t_state = RUN_STOPPED;
      t_left  = '0;
      return BEEP_TONE_OFF;
   endfunction

   function automatic void timer_clear();
      lag_reg    = '0;
      t_state    = RUN_STOPPED;
      t_now      = '0;
      t_resume   = '0;
      t_left     = '0;
      t_acc      = '0;
      t_seg      = '0;
      t_lag_done = 1'b0;
      t_stopped  = 1'b0;
   endfunction

   // Apply one request to the predicted state and return the status it gives
   function automatic etm_result_type timer_predict(input etm_req_type rq);
      logic [BEEP_W-1:0] beep;
      logic              pok;
      logic [TIME_W-1:0] got;
      etm_result_type    res;
      beep = BEEP_NONE;
      pok  = 1'b0;
      case (rq.cmd)
         CMD_TICK: begin
            t_now     = rq.now_ms;
            t_stopped = 1'b0;
            if (t_state == RUN_ACTIVE) begin
               if (t_now >= stop_at()) begin
                  t_stopped = 1'b1;
                  beep      = halt_run();
               end else begin
                  seg_refresh();
                  // Start the continuous tone once a whole tenth has been exposed
                  if (!t_lag_done && exposed_ms() / TIME_W'(MS_PER_TENTH) != '0) begin
                     t_lag_done = 1'b1;
                     beep       = BEEP_TONE_ON;
                  end
               end
            end
         end
         CMD_START: begin
            beep = BEEP_SHORT;
            if (rq.duration_tenths == '0) begin
               t_stopped = 1'b1;
            end else begin
               t_lag_done = 1'b0;
               t_left     = TIME_W'(rq.duration_tenths) * TIME_W'(MS_PER_TENTH);
               t_resume   = t_now;
               t_state    = RUN_ACTIVE;
               seg_refresh();
            end
         end
         CMD_PAUSE: begin
            if (t_state == RUN_ACTIVE) begin
               beep = BEEP_TONE_OFF;
               seg_refresh();
               got     = exposed_ms();
               t_acc   = t_acc + got;
               t_left  = t_left - got;
               t_state = RUN_PAUSED;
               pok     = t_now > t_resume + TIME_W'(lag_reg);
            end
         end
         CMD_RESUME: begin
            if (t_state == RUN_PAUSED) begin
               beep       = BEEP_SHORT;
               t_lag_done = 1'b0;
               t_resume   = t_now;
               t_state    = RUN_ACTIVE;
            end
         end
         CMD_STOP: begin
            beep = halt_run();
         end
         CMD_RESET: begin
            beep  = halt_run();
            t_acc = '0;
            t_seg = '0;
         end
         CMD_RESET_TOTAL: begin
            t_acc = '0;
         end
         default: begin
         end
      endcase

      got = exposed_ms();
      res.relay_on     = t_state == RUN_ACTIVE;
      res.run_state    = t_state;
      res.just_stopped = t_stopped;
      res.beep_cmd     = beep;
      res.pause_ok     = pok;
      res.in_lag       = (t_state == RUN_ACTIVE) && (got == '0);
      res.left_ms      = (t_state == RUN_ACTIVE && got != '0) ? stop_at() - t_now : t_left;
      res.total_tenths = tenths_sat(t_acc + got);
      res.last_segment_tenths = (t_seg > 16'(SAT_TENTHS)) ? SAT_TENTHS
                                                          : t_seg[TENTHS_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   function automatic void push_req(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                                    input logic [TENTHS_W-1:0] d);
      etm_req_type rq;
      rq.cmd             = c;
      rq.now_ms          = t;
      rq.duration_tenths = d;
      cmd_backlog.push_back(rq);
      queued_total++;
   endfunction

   // Fields that a command ignores carry random bits
   function automatic void queue_cmd(input logic [CMD_W-1:0] c);
      push_req(c, $urandom(), TENTHS_W'($urandom()));
   endfunction

   function automatic void queue_at(input logic [TIME_W-1:0] t);
      push_req(CMD_TICK, t, TENTHS_W'($urandom()));
   endfunction

   function automatic void queue_start(input logic [TENTHS_W-1:0] d);
      push_req(CMD_START, $urandom(), d);
   endfunction

   // Advance the wall clock by a fraction of the run span and tick
   function automatic void queue_tick(input logic [TIME_W-1:0] span);
      gen_now = gen_now + $urandom_range(0, span / 3 + 50);
      queue_at(gen_now);
   endfunction

   // One well-formed exposure: start, ticks, perhaps a pause and resume, then an ending
   function automatic void queue_session();
      logic [TENTHS_W-1:0] dur;
      logic [TIME_W-1:0]   span;
      int unsigned         pick;
      pick = $urandom_range(99);
      if (pick < 4) begin
         dur = '0;
      end else if (pick < 10) begin
         dur = TENTHS_W'($urandom_range(0, 32767));
      end else if (pick < 13) begin
         dur = SAT_TENTHS;
      end else begin
         dur = TENTHS_W'($urandom_range(1, 40));
      end
      span = TIME_W'(dur) * TIME_W'(MS_PER_TENTH) + TIME_W'(lag_reg);
      queue_start(dur);
      repeat ($urandom_range(1, 6)) queue_tick(span);
      if ($urandom_range(99) < 40) begin
         queue_cmd(CMD_PAUSE);
         repeat ($urandom_range(0, 2)) queue_tick(span);
         if ($urandom_range(99) < 80) begin
            queue_cmd(CMD_RESUME);
         end
         repeat ($urandom_range(1, 5)) queue_tick(span);
      end
      case ($urandom_range(5))
         0: queue_cmd(CMD_STOP);
         1: queue_cmd(CMD_RESET);
         2: begin
            // Jump past the stop time so the tick ends the run
            gen_now = gen_now + span + $urandom_range(0, 500);
            queue_at(gen_now);
         end
         default: begin
            repeat ($urandom_range(1, 4)) queue_tick(span);
         end
      endcase
      if ($urandom_range(9) == 0) begin
         queue_cmd(CMD_RESET_TOTAL);
      end
   endfunction

   // Any code, any time, any duration; a random tick may also drag the wall clock along
   function automatic void queue_noise();
      logic [CMD_W-1:0]  c;
      logic [TIME_W-1:0] t;
      c = CMD_W'($urandom_range(0, 7));
      t = $urandom();
      push_req(c, t, TENTHS_W'($urandom()));
      if (c == CMD_TICK && $urandom_range(1) == 1) begin
         gen_now = t;
      end
   endfunction

   function automatic void queue_random(input int count);
      int goal;
      goal = queued_total + count;
      while (queued_total < goal) begin
         if ($urandom_range(99) < 15) begin
            queue_noise();
         end else begin
            queue_session();
         end
      end
   endfunction

   // Corner cases first: ignored commands, zero and full durations, the lag boundary,
   // an exact stop time, a wrapping clock and a saturating total. Lag is 300 ms here.
   function automatic void queue_directed();
      queue_at(32'd0);
      queue_cmd(CMD_SPARE);
      queue_cmd(CMD_PAUSE);
      queue_cmd(CMD_RESUME);
      queue_cmd(CMD_STOP);
      queue_start(15'd0);
      queue_at(32'd100);
      queue_start(SAT_TENTHS);
      queue_at(32'd400);
      queue_at(32'd550);
      queue_cmd(CMD_PAUSE);
      queue_at(32'd2000);
      queue_cmd(CMD_RESUME);
      queue_at(32'd2200);
      queue_cmd(CMD_PAUSE);
      queue_cmd(CMD_STOP);
      queue_start(15'd1);
      queue_at(32'd2600);
      queue_cmd(CMD_RESET_TOTAL);
      queue_at(32'hFFFF_FFF0);
      queue_start(SAT_TENTHS);
      queue_at(32'h0000_0200);
      queue_at(32'd3_400_000);
      queue_start(SAT_TENTHS);
      queue_at(32'd6_800_000);
      queue_cmd(CMD_RESET);
      gen_now = 32'd6_800_000;
   endfunction

   // ------------------------------------------------------------------
   // Sequencing helpers
   // ------------------------------------------------------------------

   // Hold until every queued request has been taken and answered, then let the pipe settle
   task automatic wait_quiet();
      while (cmd_backlog.size() != 0 || req_chan.valid || status_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_lag(input logic [LAG_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      lag_reg = value;
      lag_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(input string what, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Request driver: offer the next backlog entry whenever the slot is free
   // ------------------------------------------------------------------

   always @(posedge clock) begin : req_driver
      logic take;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         // Predict the response as soon as the request is taken
         if (req_chan.valid && req_chan.ready) begin
            status_due.push_back(timer_predict(held_rq));
            sent_count++;
         end
         // Only touch the bus when nothing is waiting on it
         if (!req_chan.valid || req_chan.ready) begin
            take = cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT);
            if (take) begin
               held_rq = cmd_backlog.pop_front();
               req_chan.cmd             <= held_rq.cmd;
               req_chan.now_ms          <= held_rq.now_ms;
               req_chan.duration_tenths <= held_rq.duration_tenths;
               req_chan.valid           <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: score each response, then choose ready for the next cycle
   // ------------------------------------------------------------------

   always @(posedge clock) begin : rsp_monitor
      etm_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (status_due.size() == 0) begin
            $display("%0t ns: response with no request outstanding, expected none, actual %0d",
                     $time, rsp_chan.left_ms);
            mismatches++;
         end else begin
            want = status_due.pop_front();
            checked_count++;
            check_field("relay_on", want.relay_on, rsp_chan.relay_on);
            check_field("run_state", want.run_state, rsp_chan.run_state);
            check_field("just_stopped", want.just_stopped, rsp_chan.just_stopped);
            check_field("beep_cmd", want.beep_cmd, rsp_chan.beep_cmd);
            check_field("pause_ok", want.pause_ok, rsp_chan.pause_ok);
            check_field("in_lag", want.in_lag, rsp_chan.in_lag);
            check_field("left_ms", want.left_ms, rsp_chan.left_ms);
            check_field("total_tenths", want.total_tenths, rsp_chan.total_tenths);
            check_field("last_segment_tenths", want.last_segment_tenths,
                        rsp_chan.last_segment_tenths);
         end
      end
      // A requested hold-off keeps ready low for a fixed stretch so the pipe fills
      if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (stall_asks != stall_served) begin
         stall_served   <= stall_served + 1;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // ------------------------------------------------------------------
   // Run sequence
   // ------------------------------------------------------------------

   initial begin
      // Drive every input to a known level before the first edge
      reset                    = 1'b1;
      csr_wr_en                = 1'b0;
      csr_wr_data              = '0;
      req_chan.valid           = 1'b0;
      req_chan.cmd             = CMD_TICK;
      req_chan.now_ms          = '0;
      req_chan.duration_tenths = '0;
      rsp_chan.ready           = 1'b0;
      steady        = 1'b0;
      stall_asks    = 0;
      stall_served  = 0;
      hold_left     = 0;
      mismatches    = 0;
      sent_count    = 0;
      checked_count = 0;
      queued_total  = 0;
      lag_writes    = 0;
      gen_now       = '0;
      timer_clear();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Moderate lag: corner cases, then random sessions
      write_lag(16'd300);
      queue_directed();
      queue_random(220);
      wait_quiet();

      // No lag: hold the receiver off while the sender keeps offering
      write_lag(16'd0);
      queue_random(100);
      stall_asks = stall_asks + 1;
      queue_random(160);
      wait_quiet();

      // Largest lag, back-to-back traffic with no idling on either side
      write_lag(16'hFFFF);
      steady = 1'b1;
      queue_random(240);
      wait_quiet();
      steady = 1'b0;

      // Small random lag: pause the sender half way until every response is in
      write_lag(LAG_W'($urandom_range(1, 1000)));
      queue_random(120);
      wait_quiet();
      queue_random(120);
      wait_quiet();

      // Full-range random lag
      write_lag(LAG_W'($urandom_range(0, 65535)));
      queue_random(240);
      wait_quiet();

      $display("Run covered %0d requests and %0d checked responses over %0d lag settings,",
               sent_count, checked_count, lag_writes);
      $display("including a held-off receiver, a drained sender pause and a no-idle phase.");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
